>>> rtl/lbbt_pkg.sv
// ============================================================================
// lbbt_pkg
// Shared codes, field widths and types for the per-label bounding box tracker.
// ============================================================================
package lbbt_pkg;

    // Field widths of the stream items
    localparam int unsigned CMD_W       = 2;
    localparam int unsigned LABEL_W     = 12;
    localparam int unsigned OUT_COORD_W = 16;

    // Packed stream widths (zero-filled to whole bytes)
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 112;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 17;
    localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 17'd256;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_VOXEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd2;

    // Extent slots of one table entry, lowest first
    localparam int unsigned F_ZMIN = 0;
    localparam int unsigned F_ZMAX = 1;
    localparam int unsigned F_YMIN = 2;
    localparam int unsigned F_YMAX = 3;
    localparam int unsigned F_XMIN = 4;
    localparam int unsigned F_XMAX = 5;
    localparam int unsigned ENTRY_FIELDS = 6;

    // Control from the datapath to the coordinate counters
    typedef struct packed {
        logic clear;    // init request: back to origin
        logic advance;  // voxel request: step raster position
    } t_coord_ctrl;

endpackage

>>> rtl/label_bounding_box_tracker.sv
// ============================================================================
// label_bounding_box_tracker
// Per-label 3D axis-aligned bounding box over a raster-streamed label volume.
// ============================================================================
// Usage:
//   Input stream (i_s_*): one request per beat; tuser holds the command
//   (init entry and reset coordinates, voxel, read entry), tdata the label.
//   Voxel coordinates come from internal raster counters (x fastest, then y,
//   then z) that step on every voxel request and return to the origin on init.
//   Output stream (o_m_*): one result per read request, carrying the label
//   and its six extents. Init and voxel requests give no result.
//   Config channel (i_cfg_*): writes size_z / size_y / size_x by index;
//   always ready, to be written only while the tracker is idle.
// Timing:
//   One request per cycle sustained. Each request reads the box table RAM,
//   and init and voxel requests write it back: the read is issued on accept,
//   the update is computed in the next cycle and written back, with the last
//   write forwarded to the following request. A read result passes stage 0
//   and the output register before it shows on o_m_tvalid.
//   If the receiver stalls, further requests are still taken until a second
//   read result would need the output register; then o_s_tready drops.
// Reset:
//   Counters return to the origin and sizes to 256. Table contents are not
//   cleared; user must init every label by init request before use; unchecked.
// ============================================================================
module label_bounding_box_tracker #(
    parameter int unsigned LABEL_COUNT = 4096,
    parameter int unsigned COORD_BITS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [lbbt_pkg::S_TDATA_W-1:0]     i_s_tdata,  // [11:0] label
    input  logic [lbbt_pkg::CMD_W-1:0]         i_s_tuser,  // [1:0] cmd
    // Output stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [11:0] label_id, [27:12] z_min, [43:28] z_max, [59:44] y_min,
    // [75:60] y_max, [91:76] x_min, [107:92] x_max
    output logic [lbbt_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // Configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lbbt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lbbt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int unsigned ADDR_W  = $clog2(LABEL_COUNT);
    localparam int unsigned ENTRY_W = lbbt_pkg::ENTRY_FIELDS * COORD_BITS;

    // Coordinate counters
    lbbt_pkg::t_coord_ctrl  coord_ctrl;
    logic [COORD_BITS-1:0]  pos_z, pos_y, pos_x;
    logic [COORD_BITS-1:0]  last_z, last_y, last_x;

    // Stage 0: accepted request with its RAM read in flight
    logic                          r_s0_valid;
    logic [lbbt_pkg::CMD_W-1:0]    r_s0_cmd;
    logic [lbbt_pkg::LABEL_W-1:0]  r_s0_label;
    logic                          r_s0_inside;
    logic [COORD_BITS-1:0]         r_s0_z, r_s0_y, r_s0_x;

    // Last table write, forwarded over the RAM read latency
    logic                 r_wr_valid;
    logic [ADDR_W-1:0]    r_wr_addr;
    logic [ENTRY_W-1:0]   r_wr_data;

    // Output register
    logic                               r_out_valid;
    logic [lbbt_pkg::M_TDATA_W-1:0]     r_out_data;

    logic                          advance;
    logic                          accept;
    logic [lbbt_pkg::CMD_W-1:0]    in_cmd;
    logic [lbbt_pkg::LABEL_W-1:0]  in_label;
    logic [ADDR_W-1:0]             s0_addr;
    logic [ENTRY_W-1:0]            ram_rd_data;
    logic [ENTRY_W-1:0]            cur_entry;
    logic [ENTRY_W-1:0]            new_entry;
    logic [ENTRY_W-1:0]            init_entry;
    logic [ENTRY_W-1:0]            upd_entry;
    logic                          wr_en;
    logic [lbbt_pkg::M_TDATA_W-1:0] n_out_data;

    assign in_cmd   = i_s_tuser;
    assign in_label = i_s_tdata[lbbt_pkg::LABEL_W-1:0];
    assign s0_addr  = ADDR_W'(r_s0_label);

    // Pipeline holds only when a read result finds the output register blocked
    assign advance = !(r_s0_valid && (r_s0_cmd == lbbt_pkg::CMD_READ)
                       && r_out_valid && !i_m_tready);
    assign o_s_tready = advance;
    assign accept     = i_s_tvalid && advance;
    assign o_cfg_ready = 1'b1;

    assign coord_ctrl.clear   = accept && (in_cmd == lbbt_pkg::CMD_INIT);
    assign coord_ctrl.advance = accept && (in_cmd == lbbt_pkg::CMD_VOXEL);

    lbbt_coord #(
        .COORD_BITS (COORD_BITS)
    ) u_coord (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_ctrl      (coord_ctrl),
        .o_pos_z     (pos_z),
        .o_pos_y     (pos_y),
        .o_pos_x     (pos_x),
        .o_last_z    (last_z),
        .o_last_y    (last_y),
        .o_last_x    (last_x)
    );

    lbbt_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (LABEL_COUNT)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (s0_addr),
        .i_wr_data (new_entry),
        .i_rd_en   (advance),
        .i_rd_addr (ADDR_W'(in_label)),
        .o_rd_data (ram_rd_data)
    );

    // Stage 0 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (advance) begin
            r_s0_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s0_cmd    <= in_cmd;
            r_s0_label  <= in_label;
            r_s0_inside <= (32'(in_label) < LABEL_COUNT);
            r_s0_z      <= pos_z;
            r_s0_y      <= pos_y;
            r_s0_x      <= pos_x;
        end
    end

    // Current entry: forward the last table write if it hit the same address
    assign cur_entry = (r_wr_valid && (r_wr_addr == s0_addr)) ? r_wr_data : ram_rd_data;

    // Fresh entry for init: min at last position, max at zero
    always_comb begin
        init_entry = '0;
        init_entry[lbbt_pkg::F_ZMIN*COORD_BITS +: COORD_BITS] = last_z;
        init_entry[lbbt_pkg::F_YMIN*COORD_BITS +: COORD_BITS] = last_y;
        init_entry[lbbt_pkg::F_XMIN*COORD_BITS +: COORD_BITS] = last_x;
    end

    // Fold voxel coordinates into the stored extents
    always_comb begin
        logic [COORD_BITS-1:0] e_zmin, e_zmax, e_ymin, e_ymax, e_xmin, e_xmax;
        e_zmin = cur_entry[lbbt_pkg::F_ZMIN*COORD_BITS +: COORD_BITS];
        e_zmax = cur_entry[lbbt_pkg::F_ZMAX*COORD_BITS +: COORD_BITS];
        e_ymin = cur_entry[lbbt_pkg::F_YMIN*COORD_BITS +: COORD_BITS];
        e_ymax = cur_entry[lbbt_pkg::F_YMAX*COORD_BITS +: COORD_BITS];
        e_xmin = cur_entry[lbbt_pkg::F_XMIN*COORD_BITS +: COORD_BITS];
        e_xmax = cur_entry[lbbt_pkg::F_XMAX*COORD_BITS +: COORD_BITS];
        upd_entry = '0;
        upd_entry[lbbt_pkg::F_ZMIN*COORD_BITS +: COORD_BITS] = (r_s0_z < e_zmin) ? r_s0_z : e_zmin;
        upd_entry[lbbt_pkg::F_ZMAX*COORD_BITS +: COORD_BITS] = (r_s0_z > e_zmax) ? r_s0_z : e_zmax;
        upd_entry[lbbt_pkg::F_YMIN*COORD_BITS +: COORD_BITS] = (r_s0_y < e_ymin) ? r_s0_y : e_ymin;
        upd_entry[lbbt_pkg::F_YMAX*COORD_BITS +: COORD_BITS] = (r_s0_y > e_ymax) ? r_s0_y : e_ymax;
        upd_entry[lbbt_pkg::F_XMIN*COORD_BITS +: COORD_BITS] = (r_s0_x < e_xmin) ? r_s0_x : e_xmin;
        upd_entry[lbbt_pkg::F_XMAX*COORD_BITS +: COORD_BITS] = (r_s0_x > e_xmax) ? r_s0_x : e_xmax;
    end

    // Write-back select: init writes any label in range, voxel skips background
    assign new_entry = (r_s0_cmd == lbbt_pkg::CMD_INIT) ? init_entry : upd_entry;
    assign wr_en = advance && r_s0_valid && r_s0_inside
                   && ((r_s0_cmd == lbbt_pkg::CMD_INIT)
                       || ((r_s0_cmd == lbbt_pkg::CMD_VOXEL) && (r_s0_label != '0)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_valid <= 1'b0;
        end else if (wr_en) begin
            r_wr_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wr_addr <= s0_addr;
            r_wr_data <= new_entry;
        end
    end

    // Result packing; labels beyond the table report zero extents
    always_comb begin
        n_out_data = '0;
        n_out_data[lbbt_pkg::LABEL_W-1:0] = r_s0_label;
        if (r_s0_inside) begin
            for (int k = 0; k < lbbt_pkg::ENTRY_FIELDS; k++) begin
                n_out_data[lbbt_pkg::LABEL_W + k*lbbt_pkg::OUT_COORD_W +: lbbt_pkg::OUT_COORD_W] =
                    lbbt_pkg::OUT_COORD_W'(cur_entry[k*COORD_BITS +: COORD_BITS]);
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_s0_valid && (r_s0_cmd == lbbt_pkg::CMD_READ)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s0_valid && (r_s0_cmd == lbbt_pkg::CMD_READ)) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

>>> rtl/lbbt_ram.sv
// ============================================================================
// lbbt_ram
// Generic single-port-write, single-port-read RAM with registered read.
// A read at the address being written returns the old contents.
// ============================================================================
module lbbt_ram #(
    parameter int unsigned DATA_W = 96,
    parameter int unsigned DEPTH  = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/lbbt_coord.sv
// ============================================================================
// lbbt_coord
// Raster coordinate counters (x fastest, then y, then z) and the per-axis
// last-position registers loaded from the size configuration.
// ============================================================================
module lbbt_coord #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [lbbt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lbbt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  lbbt_pkg::t_coord_ctrl             i_ctrl,
    output logic [COORD_BITS-1:0]             o_pos_z,
    output logic [COORD_BITS-1:0]             o_pos_y,
    output logic [COORD_BITS-1:0]             o_pos_x,
    output logic [COORD_BITS-1:0]             o_last_z,
    output logic [COORD_BITS-1:0]             o_last_y,
    output logic [COORD_BITS-1:0]             o_last_x
);

    localparam logic [lbbt_pkg::CFG_DATA_W-1:0] SPAN =
        lbbt_pkg::CFG_DATA_W'(33'd1 << COORD_BITS);

    // Last valid position for a size, with size clamped to 1..SPAN
    function automatic logic [COORD_BITS-1:0] last_index(
        input logic [lbbt_pkg::CFG_DATA_W-1:0] size
    );
        logic [lbbt_pkg::CFG_DATA_W-1:0] s;
        s = size;
        if (s == '0) s = lbbt_pkg::CFG_DATA_W'(1);
        if (s > SPAN) s = SPAN;
        return COORD_BITS'(s - lbbt_pkg::CFG_DATA_W'(1));
    endfunction

    logic [COORD_BITS-1:0] r_last_z, r_last_y, r_last_x;
    logic [COORD_BITS-1:0] r_pos_z, r_pos_y, r_pos_x;
    logic [COORD_BITS-1:0] n_pos_z, n_pos_y, n_pos_x;

    // Size registers, stored as last position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_z <= last_index(lbbt_pkg::SIZE_RESET);
            r_last_y <= last_index(lbbt_pkg::SIZE_RESET);
            r_last_x <= last_index(lbbt_pkg::SIZE_RESET);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lbbt_pkg::REG_SIZE_Z: r_last_z <= last_index(i_cfg_data);
                lbbt_pkg::REG_SIZE_Y: r_last_y <= last_index(i_cfg_data);
                lbbt_pkg::REG_SIZE_X: r_last_x <= last_index(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Raster step with wrap and carry
    always_comb begin
        n_pos_z = r_pos_z;
        n_pos_y = r_pos_y;
        n_pos_x = r_pos_x;
        if (i_ctrl.clear) begin
            n_pos_z = '0;
            n_pos_y = '0;
            n_pos_x = '0;
        end else if (i_ctrl.advance) begin
            if (r_pos_x >= r_last_x) begin
                n_pos_x = '0;
                if (r_pos_y >= r_last_y) begin
                    n_pos_y = '0;
                    n_pos_z = (r_pos_z >= r_last_z) ? '0 : r_pos_z + 1'b1;
                end else begin
                    n_pos_y = r_pos_y + 1'b1;
                end
            end else begin
                n_pos_x = r_pos_x + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_z <= '0;
            r_pos_y <= '0;
            r_pos_x <= '0;
        end else begin
            r_pos_z <= n_pos_z;
            r_pos_y <= n_pos_y;
            r_pos_x <= n_pos_x;
        end
    end

    assign o_pos_z  = r_pos_z;
    assign o_pos_y  = r_pos_y;
    assign o_pos_x  = r_pos_x;
    assign o_last_z = r_last_z;
    assign o_last_y = r_last_y;
    assign o_last_x = r_last_x;

endmodule
